### hdl/u128a_pkg.sv
`default_nettype none
package u128a_pkg;
   localparam int unsigned OpW = 3;
   localparam logic [OpW-1:0] OP_ADD = 3'd0;
   localparam logic [OpW-1:0] OP_SUB = 3'd1;
   localparam logic [OpW-1:0] OP_MUL = 3'd2;
   localparam logic [OpW-1:0] OP_DIV = 3'd3;
   localparam logic [OpW-1:0] OP_REM = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] a_low;
      logic [63:0] a_high;
      logic [63:0] b_low;
      logic [63:0] b_high;
      logic [31:0] divisor;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
      logic        divide_error;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [2:0]   opcode;
      logic [127:0] a;
      logic [127:0] b;
      logic [31:0]  divisor;
      logic         div_zero;
   } cmd_type;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned DivSteps   = 4;
   localparam int unsigned DivStages  = 128 / DivSteps;
endpackage
`default_nettype wire

### hdl/u128a_req_if.sv
`default_nettype none
interface u128a_req_if;
   import u128a_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/u128a_rsp_if.sv
`default_nettype none
interface u128a_rsp_if;
   import u128a_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/u128a_front.sv
`default_nettype none
module u128a_front (
   input  wire logic               clock,
   input  wire logic               reset,
   u128a_req_if.sink               req,
   output u128a_pkg::cmd_type      cmd,
   output logic                    cmd_valid,
   input  wire logic               cmd_ready
);
   import u128a_pkg::*;

   // two-entry queue between front and back
   cmd_type        mem_ff [QueueDepth];
   logic           wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]     cnt_ff, cnt_in;
   cmd_type        c;
   logic           push, pop;

   always_comb begin
      c.opcode   = req.payload.opcode;
      c.a        = {req.payload.a_high, req.payload.a_low};
      c.b        = {req.payload.b_high, req.payload.b_low};
      c.divisor  = req.payload.divisor;
      c.div_zero = (req.payload.divisor == 32'd0);
   end

   assign req.ready = (cnt_ff != 2'(QueueDepth));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= c;
      end
   end
endmodule
`default_nettype wire

### hdl/u128a_back.sv
`default_nettype none
module u128a_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire u128a_pkg::cmd_type cmd,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   u128a_rsp_if.source             rsp
);
   import u128a_pkg::*;

   localparam int unsigned NStg = DivStages + 2;

   // pipeline stage contents: stage 0 holds partial products, then 32 radix-16
   // divide stages, then the output register
   logic [NStg-1:0]  vld_ff;
   logic [2:0]       op_ff   [NStg-1];
   logic             dz_ff   [NStg-1];
   logic [127:0]     sum_ff  [NStg-1];
   logic [31:0]      dv_ff   [DivStages];
   logic [127:0]     q_ff    [NStg-1];
   logic [31:0]      r_ff    [NStg-1];
   logic [63:0]      p0_ff, p1_ff, p2_ff, p3_ff, xa_ff, xb_ff;
   logic [31:0]      xc_ff, xd_ff, xe_ff, xf_ff;
   logic             adv;
   logic [127:0]     addsub;
   logic [127:0]     mulres;
   rsp_type          out_c;

   // pipeline advances unless the output register is full and stalled
   assign adv       = !rsp.valid || rsp.ready || !vld_ff[NStg-1];
   assign cmd_ready = adv;

   always_comb begin
      unique case (cmd.opcode)
         OP_SUB:  addsub = cmd.a - cmd.b;
         default: addsub = cmd.a + cmd.b;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NStg-2:0], cmd_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0]  <= cmd.opcode;
         dz_ff[0]  <= cmd.div_zero;
         sum_ff[0] <= addsub;
         dv_ff[0]  <= cmd.divisor;
         q_ff[0]   <= cmd.a;
         r_ff[0]   <= 32'd0;
         p0_ff     <= cmd.a[31:0]  * cmd.b[31:0];
         p1_ff     <= cmd.a[31:0]  * cmd.b[63:32];
         p2_ff     <= cmd.a[63:32] * cmd.b[31:0];
         p3_ff     <= cmd.a[63:32] * cmd.b[63:32];
         // cross terms: only the low 64 bits of a_high*b_low and a_low*b_high count
         xa_ff     <= cmd.a[95:64]  * cmd.b[31:0];
         xc_ff     <= cmd.a[95:64]  * cmd.b[63:32];
         xd_ff     <= cmd.a[127:96] * cmd.b[31:0];
         xb_ff     <= cmd.a[31:0]   * cmd.b[95:64];
         xe_ff     <= cmd.a[31:0]   * cmd.b[127:96];
         xf_ff     <= cmd.a[63:32]  * cmd.b[95:64];
      end
   end

   // combine partial products at the first divide stage boundary
   logic [63:0] mid;
   logic [63:0] cr;
   always_comb begin
      cr     = xa_ff + xb_ff + {xc_ff + xd_ff + xe_ff + xf_ff, 32'd0};
      mid    = {32'd0, p0_ff[63:32]} + {32'd0, p1_ff[31:0]} + {32'd0, p2_ff[31:0]};
      mulres = {p3_ff + {32'd0, p1_ff[63:32]} + {32'd0, p2_ff[63:32]}
                + {32'd0, mid[63:32]} + cr, mid[31:0], p0_ff[31:0]};
   end

   genvar g;
   generate
      for (g = 1; g <= DivStages; g++) begin : g_div
         logic [31:0]  r_c;
         logic [127:0] q_c;
         logic [32:0]  t;
         always_comb begin
            r_c = r_ff[g-1];
            q_c = q_ff[g-1];
            for (int k = 0; k < DivSteps; k++) begin
               t   = {r_c, q_c[127]};
               q_c = {q_c[126:0], 1'b0};
               if (t >= {1'b0, dv_ff[g-1]}) begin
                  t      = t - {1'b0, dv_ff[g-1]};
                  q_c[0] = 1'b1;
               end
               r_c = t[31:0];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               op_ff[g]  <= op_ff[g-1];
               dz_ff[g]  <= dz_ff[g-1];
               sum_ff[g] <= (g == 1 && op_ff[0] == OP_MUL) ? mulres : sum_ff[g-1];
               q_ff[g]   <= q_c;
               r_ff[g]   <= r_c;
            end
         end
         if (g < DivStages) begin : g_dv
            always_ff @(posedge clock) begin
               if (adv) begin
                  dv_ff[g] <= dv_ff[g-1];
               end
            end
         end
      end
   endgenerate

   always_comb begin
      out_c = '0;
      unique case (op_ff[NStg-2])
         OP_ADD, OP_SUB, OP_MUL: begin
            out_c.result_low  = sum_ff[NStg-2][63:0];
            out_c.result_high = sum_ff[NStg-2][127:64];
         end
         OP_DIV: begin
            out_c.divide_error = dz_ff[NStg-2];
            if (!dz_ff[NStg-2]) begin
               out_c.result_low  = q_ff[NStg-2][63:0];
               out_c.result_high = q_ff[NStg-2][127:64];
            end
         end
         OP_REM: begin
            out_c.divide_error = dz_ff[NStg-2];
            if (!dz_ff[NStg-2]) begin
               out_c.result_low = {32'd0, r_ff[NStg-2]};
            end
         end
         default: out_c = '0;
      endcase
   end

   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_c;
      end
   end

   assign rsp.valid   = vld_ff[NStg-1];
   assign rsp.payload = out_ff;
endmodule
`default_nettype wire

### hdl/uint128_arith_unit.sv
// Path from request accept to result valid: queue, operand
// stage, 32 divide stages of 4 quotient bits each, output register.
// Throughput: one request per cycle while the response side is not stalled.
// Reset: synchronous, active high; clears queue and stage valid bits.
`default_nettype none
module uint128_arith_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   u128a_req_if.sink   req,
   u128a_rsp_if.source rsp
);
   import u128a_pkg::*;

   cmd_type cmd;
   logic    cmd_valid, cmd_ready;

   u128a_front u_front (
      .clock, .reset, .req, .cmd, .cmd_valid, .cmd_ready
   );

   u128a_back u_back (
      .clock, .reset, .cmd, .cmd_valid, .cmd_ready, .rsp
   );
endmodule
`default_nettype wire
